@@ hw/rtl/pfe_pkg.sv @@
package pfe_pkg;

   localparam int PFE_PALETTE_ENTRIES = 256;
   localparam int PFE_STEP_BASE       = 2;
   localparam int PFE_STEP_SHIFT      = 5;   // divide by 32

   typedef enum logic [1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_TICK = 2'd1,
      FUNC_READ = 2'd2,
      FUNC_NOP  = 2'd3
   } pfe_func_type;

   typedef enum logic [0:0] {
      CSR_FIRST_ENTRY = 1'b0,
      CSR_ENTRY_COUNT = 1'b1
   } pfe_csr_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_TICK,
      ST_DRAIN,
      ST_DONE
   } pfe_state_type;

   typedef struct packed {
      logic [7:0]        cur;
      logic [7:0]        tgt;
      logic signed [4:0] step;
   } pfe_word_type;

   typedef struct packed {
      pfe_word_type word;
      logic         active;
   } pfe_upd_type;

endpackage

@@ hw/rtl/pfe_comp_ram.sv @@
module pfe_comp_ram #(
   parameter int PALETTE_ENTRIES = pfe_pkg::PFE_PALETTE_ENTRIES,
   parameter int ADDR_WIDTH      = $clog2(3 * PALETTE_ENTRIES)
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_WIDTH-1:0]  wr_addr,
   input  pfe_pkg::pfe_word_type  wr_data,
   input  logic [ADDR_WIDTH-1:0]  rd_addr,
   output pfe_pkg::pfe_word_type  rd_data
);
   import pfe_pkg::*;

   localparam int DEPTH = 3 * PALETTE_ENTRIES;

   pfe_word_type mem [DEPTH];
   pfe_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/pfe_comp_update.sv @@
module pfe_comp_update (
   input  pfe_pkg::pfe_word_type word,
   output pfe_pkg::pfe_upd_type  upd
);
   import pfe_pkg::*;

   logic [4:0] step_abs;
   logic [7:0] diff;

   always_comb begin
      step_abs = word.step[4] ? (~word.step + 5'd1) : word.step;
      diff     = (word.cur > word.tgt) ? (word.cur - word.tgt) : (word.tgt - word.cur);
      upd.word = word;
      upd.active = (word.step != 5'sd0);
      if (upd.active) begin
         if (diff <= {3'b000, step_abs}) begin
            upd.word.cur  = word.tgt;
            upd.word.step = 5'sd0;
         end else begin
            upd.word.cur = word.cur + {{3{word.step[4]}}, word.step};
         end
      end
   end

endmodule

@@ hw/rtl/palette_fade_engine_unit.sv @@
// Palette fade engine. Each colour component (three per palette entry) holds
// a current value, a target and a signed step in one on-chip memory. A
// tick while a fade runs walks the clipped range one memory read-modify-write
// per component. After reset a clearing pass over all 3*PALETTE_ENTRIES
// components (768 at the default size) zeroes all steps with req_ready low;
// csr writes are always taken.
module palette_fade_engine_unit #(
   parameter int PALETTE_ENTRIES = pfe_pkg::PFE_PALETTE_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [9:0]  req_component_index,
   input  logic [7:0]  req_current_value,
   input  logic [7:0]  req_target_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_value,
   output logic        rsp_running,
   output logic        rsp_stepped,
   output logic        rsp_finished,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import pfe_pkg::*;

   localparam int COMPONENTS = 3 * PALETTE_ENTRIES;
   localparam int AW  = $clog2(COMPONENTS);
   localparam int IW  = (AW > 10) ? AW : 10;
   localparam int EWB = $clog2(PALETTE_ENTRIES + 1);
   localparam int RW  = (EWB > 10) ? EWB : 10;
   localparam int PW  = RW + 2;

   function automatic logic signed [4:0] load_step(input logic [7:0] cur,
                                                   input logic [7:0] tgt);
      logic [7:0] diff;
      logic [4:0] mag;
      diff = (tgt > cur) ? (tgt - cur) : (cur - tgt);
      mag  = 5'(PFE_STEP_BASE) + 5'(diff >> PFE_STEP_SHIFT);
      if (tgt > cur)      load_step = mag;
      else if (tgt < cur) load_step = ~mag + 5'd1;
      else                load_step = 5'sd0;
   endfunction

   pfe_state_type state_ff, state_in;

   logic [7:0]    first_entry_ff;
   logic [8:0]    entry_count_ff;
   logic          fade_running_ff, fade_running_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] k_ff, k_in;
   logic [AW-1:0] last_ff, last_in;
   logic [AW-1:0] rd_hold_ff, rd_hold_in;
   logic [AW-1:0] pend_addr_ff;
   logic          pend_ff;
   logic          active_ff, active_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_read_value_ff, rsp_read_value_in;
   logic          rsp_running_ff, rsp_running_in;
   logic          rsp_stepped_ff, rsp_stepped_in;
   logic          rsp_finished_ff, rsp_finished_in;

   logic          slot_free, accept, emit, idx_ok, range_empty;
   pfe_func_type  func;
   logic [IW-1:0] idx_w;
   logic [AW-1:0] idx_addr;
   logic [RW-1:0] sum_w, hi_w;
   logic [PW-1:0] lo3_w, hi3_w;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   pfe_word_type  mem_wr_data, mem_rd_data;
   pfe_upd_type   upd;

   pfe_comp_ram #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .ADDR_WIDTH      (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pfe_comp_update u_update (
      .word (mem_rd_data),
      .upd  (upd)
   );

   assign func        = pfe_func_type'(req_func);
   assign idx_w       = IW'(req_component_index);
   assign idx_ok      = idx_w < IW'(COMPONENTS);
   assign idx_addr    = idx_w[AW-1:0];
   assign sum_w       = RW'(first_entry_ff) + RW'(entry_count_ff);
   assign hi_w        = (sum_w > RW'(PALETTE_ENTRIES)) ? RW'(PALETTE_ENTRIES) : sum_w;
   assign range_empty = RW'(first_entry_ff) >= hi_w;
   assign lo3_w       = PW'(first_entry_ff) * PW'(3);
   assign hi3_w       = PW'(hi_w) * PW'(3);
   assign slot_free   = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(COMPONENTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && slot_free) begin
               if (func == FUNC_READ && idx_ok) begin
                  state_in = ST_READ;
               end else if (func == FUNC_TICK && fade_running_ff) begin
                  state_in = range_empty ? ST_DONE : ST_TICK;
               end
            end
         end
         ST_READ: begin
            if (slot_free) state_in = ST_IDLE;
         end
         ST_TICK: begin
            if (k_ff == last_ff) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready         = 1'b0;
      accept            = 1'b0;
      emit              = 1'b0;
      rsp_read_value_in = 8'd0;
      rsp_running_in    = fade_running_ff;
      rsp_stepped_in    = 1'b0;
      rsp_finished_in   = 1'b0;
      fade_running_in   = fade_running_ff;
      clr_in            = clr_ff;
      k_in              = k_ff;
      last_in           = last_ff;
      rd_hold_in        = rd_hold_ff;
      active_in         = active_ff | (pend_ff & upd.active);
      mem_rd_addr       = rd_hold_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            req_ready   = slot_free;
            accept      = req_valid && slot_free;
            mem_rd_addr = idx_addr;
            rd_hold_in  = idx_addr;
            k_in        = lo3_w[AW-1:0];
            last_in     = AW'(hi3_w - PW'(1));
            if (accept) begin
               active_in = 1'b0;
               unique case (func)
                  FUNC_LOAD: begin
                     emit = 1'b1;
                     if (idx_ok) begin
                        fade_running_in = 1'b1;
                        rsp_running_in  = 1'b1;
                     end
                  end
                  FUNC_TICK: begin
                     emit = !fade_running_ff;
                  end
                  FUNC_READ: begin
                     emit = !idx_ok;
                  end
                  FUNC_NOP: begin
                     emit = 1'b1;
                  end
                  default: emit = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            emit              = slot_free;
            rsp_read_value_in = mem_rd_data.cur;
         end
         ST_TICK: begin
            mem_rd_addr = k_ff;
            k_in        = k_ff + AW'(1);
         end
         ST_DRAIN: begin
         end
         ST_DONE: begin
            emit            = slot_free;
            rsp_stepped_in  = 1'b1;
            rsp_finished_in = !active_ff;
            rsp_running_in  = active_ff;
            if (slot_free) fade_running_in = active_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = pend_addr_ff;
      mem_wr_data = upd.word;
      priority if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_ff;
         mem_wr_data = '0;
      end else if (pend_ff) begin
         mem_wr_en = 1'b1;
      end else if (accept && func == FUNC_LOAD && idx_ok) begin
         mem_wr_en        = 1'b1;
         mem_wr_addr      = idx_addr;
         mem_wr_data.cur  = req_current_value;
         mem_wr_data.tgt  = req_target_value;
         mem_wr_data.step = load_step(req_current_value, req_target_value);
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         pend_ff         <= 1'b0;
         fade_running_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         first_entry_ff  <= 8'd0;
         entry_count_ff  <= 9'd256;
      end else begin
         state_ff        <= state_in;
         clr_ff          <= clr_in;
         pend_ff         <= (state_ff == ST_TICK);
         fade_running_ff <= fade_running_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_valid) begin
            unique case (pfe_csr_type'(csr_index))
               CSR_FIRST_ENTRY: first_entry_ff <= csr_data[7:0];
               CSR_ENTRY_COUNT: entry_count_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      last_ff      <= last_in;
      rd_hold_ff   <= rd_hold_in;
      active_ff    <= active_in;
      pend_addr_ff <= k_ff;
      if (emit) begin
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_running_ff    <= rsp_running_in;
         rsp_stepped_ff    <= rsp_stepped_in;
         rsp_finished_ff   <= rsp_finished_in;
      end
   end

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_running    = rsp_running_ff;
   assign rsp_stepped    = rsp_stepped_ff;
   assign rsp_finished   = rsp_finished_ff;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("request taken during clearing pass");

   a_pend_no_accept: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !accept)
      else $error("request accepted while tick write-back pending");

   a_finish_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_stepped && !rsp_running)
      else $error("finished beat without stepped or with running");

   a_tick_drains: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> pend_ff ##1 !pend_ff)
      else $error("tick pipeline not drained");

endmodule

@@ test/palette_fade_engine_unit_test.sv @@
module palette_fade_engine_unit_test;
   import pfe_pkg::*;

   localparam int NUM_COMP = 3 * PFE_PALETTE_ENTRIES;
   localparam int ITEM_TARGET = 780;
   localparam int CYCLE_LIMIT = 3_000_000;

   typedef struct {
      logic [7:0] read_value;
      logic       running;
      logic       stepped;
      logic       finished;
   } fade_result_type;

   class palette_fade_scoreboard;
      logic [7:0]        cur_mem[NUM_COMP];
      logic [7:0]        tgt_mem[NUM_COMP];
      logic signed [4:0] step_mem[NUM_COMP];
      bit                fading;
      int                first_entry;
      int                entry_count;
      fade_result_type   expected_q[$];
      int mismatches, n_checked, n_loads, n_reads, n_steps, n_finishes;

      function new();
         foreach (step_mem[k]) begin
            cur_mem[k] = '0;
            tgt_mem[k] = '0;
            step_mem[k] = '0;
         end
         fading = 1'b0;
         first_entry = 0;
         entry_count = PFE_PALETTE_ENTRIES;
      endfunction

      function void set_register(pfe_csr_type idx, logic [8:0] data);
         if (idx == CSR_FIRST_ENTRY) begin
            first_entry = data[7:0];
         end else begin
            entry_count = data;
         end
      endfunction

      function logic signed [4:0] step_for(int c, int t);
         if (t > c) return 5'(PFE_STEP_BASE + ((t - c) >> PFE_STEP_SHIFT));
         if (t < c) return 5'(-(PFE_STEP_BASE + ((c - t) >> PFE_STEP_SHIFT)));
         return '0;
      endfunction

      // one fade step over the clipped range; returns 1 if anything moved
      function bit advance_fade();
         int lo, hi, k, s, c, t, d, mag;
         bit active;
         active = 1'b0;
         lo = first_entry;
         hi = first_entry + entry_count;
         if (hi > PFE_PALETTE_ENTRIES) hi = PFE_PALETTE_ENTRIES;
         for (k = 3 * lo; k < 3 * hi; k++) begin
            s = step_mem[k];
            if (s != 0) begin
               active = 1'b1;
               c = cur_mem[k];
               t = tgt_mem[k];
               d = (c > t) ? c - t : t - c;
               mag = (s < 0) ? -s : s;
               if (d <= mag) begin
                  cur_mem[k] = 8'(t);
                  step_mem[k] = '0;
               end else begin
                  cur_mem[k] = 8'(c + s);
               end
            end
         end
         return active;
      endfunction

      function void note_request(pfe_func_type func, logic [9:0] idx,
                                 logic [7:0] cur, logic [7:0] tgt);
         fade_result_type r;
         r.read_value = '0;
         r.stepped = 1'b0;
         r.finished = 1'b0;
         case (func)
            FUNC_LOAD: begin
               if (idx < NUM_COMP) begin
                  cur_mem[idx] = cur;
                  tgt_mem[idx] = tgt;
                  step_mem[idx] = step_for(cur, tgt);
                  fading = 1'b1;
                  n_loads++;
               end
            end
            FUNC_TICK: begin
               if (fading) begin
                  r.stepped = 1'b1;
                  n_steps++;
                  if (!advance_fade()) begin
                     fading = 1'b0;
                     r.finished = 1'b1;
                     n_finishes++;
                  end
               end
            end
            FUNC_READ: begin
               if (idx < NUM_COMP) begin
                  r.read_value = cur_mem[idx];
                  n_reads++;
               end
            end
            default: ;
         endcase
         r.running = fading;
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string what);
         $display("mismatch at result %0d: %s", n_checked, what);
         mismatches++;
      endtask

      task check_response(logic [7:0] rv, logic running, logic stepped, logic finished);
         fade_result_type e;
         n_checked++;
         if (expected_q.size() == 0) begin
            report_mismatch("result with nothing expected");
            return;
         end
         e = expected_q.pop_front();
         if (rv !== e.read_value)
            report_mismatch($sformatf("read_value %0h, expected %0h", rv, e.read_value));
         if (running !== e.running)
            report_mismatch($sformatf("running %b, expected %b", running, e.running));
         if (stepped !== e.stepped)
            report_mismatch($sformatf("stepped %b, expected %b", stepped, e.stepped));
         if (finished !== e.finished)
            report_mismatch($sformatf("finished %b, expected %b", finished, e.finished));
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   pfe_func_type req_func = FUNC_NOP;
   logic [9:0]   req_component_index = '0;
   logic [7:0]   req_current_value = '0;
   logic [7:0]   req_target_value = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b1;
   logic [7:0]   rsp_read_value;
   logic         rsp_running;
   logic         rsp_stepped;
   logic         rsp_finished;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   pfe_csr_type  csr_index = CSR_FIRST_ENTRY;
   logic [8:0]   csr_data = '0;

   palette_fade_scoreboard sb;
   bit          idle_on = 1'b1;
   int unsigned next_gap = 0;
   int unsigned rsp_hold = 0;
   int          n_items = 0;
   int          n_settings = 0;
   int          cycles = 0;
   bit          loaded[NUM_COMP];
   int          loaded_list[$];
   int          first_picks[5] = '{0, 255, 250, 128, 0};
   int          count_picks[5] = '{0, 1, 256, 100, 3};

   palette_fade_engine_unit i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic int draw_wait();
      return idle_on ? $urandom_range(0, 14) : 0;
   endfunction

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         sb.check_response(rsp_read_value, rsp_running, rsp_stepped, rsp_finished);
         rsp_hold = draw_wait();
         if (rsp_hold != 0) rsp_ready <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         if (rsp_hold == 0) rsp_ready <= 1'b1;
      end
   end

   // valid is dropped at the accepting edge only when a gap follows
   task automatic send_request(pfe_func_type func, int idx, int cur, int tgt);
      repeat (next_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_func <= func;
      req_component_index <= 10'(idx);
      req_current_value <= 8'(cur);
      req_target_value <= 8'(tgt);
      do @(posedge clock); while (!req_ready);
      sb.note_request(func, 10'(idx), 8'(cur), 8'(tgt));
      if (func == FUNC_LOAD && idx < NUM_COMP && !loaded[idx]) begin
         loaded[idx] = 1'b1;
         loaded_list.push_back(idx);
      end
      n_items++;
      next_gap = draw_wait();
      if (next_gap != 0) req_valid <= 1'b0;
   endtask

   task automatic stop_requests();
      if (next_gap == 0) req_valid <= 1'b0;
      next_gap = 0;
   endtask

   task automatic settle();
      stop_requests();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_range(int first, int count);
      csr_valid <= 1'b1;
      csr_index <= CSR_FIRST_ENTRY;
      csr_data <= 9'(first);
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_FIRST_ENTRY, 9'(first));
      csr_index <= CSR_ENTRY_COUNT;
      csr_data <= 9'(count);
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_ENTRY_COUNT, 9'(count));
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   function automatic int range_end();
      int hi;
      hi = sb.first_entry + sb.entry_count;
      return (hi > PFE_PALETTE_ENTRIES) ? PFE_PALETTE_ENTRIES : hi;
   endfunction

   function automatic bit range_empty();
      return sb.first_entry >= range_end();
   endfunction

   function automatic bit range_full();
      return sb.first_entry == 0 && range_end() == PFE_PALETTE_ENTRIES;
   endfunction

   function automatic int pick_in_range();
      return 3 * $urandom_range(sb.first_entry, range_end() - 1) + $urandom_range(0, 2);
   endfunction

   function automatic int pick_outside();
      int k;
      do k = $urandom_range(0, NUM_COMP - 1);
      while (k >= 3 * sb.first_entry && k < 3 * range_end());
      return k;
   endfunction

   task automatic load_random(int idx);
      int c, t;
      c = $urandom_range(0, 255);
      case ($urandom_range(0, 5))
         0: t = c;
         1: begin
            c = $urandom_range(0, 1) ? 0 : 255;
            t = 255 - c;
         end
         2: t = $urandom_range(0, 1) ? 0 : 255;
         3: begin
            t = c + $urandom_range(0, 6) - 3;
            if (t < 0) t = 0;
            if (t > 255) t = 255;
         end
         default: t = $urandom_range(0, 255);
      endcase
      send_request(FUNC_LOAD, idx, c, t);
   endtask

   // never touches a component that was not loaded
   task automatic read_loaded();
      if (loaded_list.size() == 0) begin
         send_request(FUNC_READ, $urandom_range(NUM_COMP, 1023), $urandom, $urandom);
      end else begin
         send_request(FUNC_READ, loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                      $urandom, $urandom);
      end
   endtask

   task automatic noise_item();
      case ($urandom_range(0, 5))
         0: send_request(FUNC_NOP, $urandom_range(0, 1023), $urandom, $urandom);
         1: send_request(FUNC_LOAD, $urandom_range(NUM_COMP, 1023), $urandom, $urandom);
         2: send_request(FUNC_READ, $urandom_range(NUM_COMP, 1023), $urandom, $urandom);
         3: begin
            if (range_full()) read_loaded();
            else load_random(pick_outside());
         end
         4: read_loaded();
         default: send_request(FUNC_TICK, $urandom_range(0, 1023), $urandom, $urandom);
      endcase
   endtask

   task automatic run_fade_phase(int first, int count);
      int loads, ticks;
      settle();
      set_range(first, count);
      idle_on = ($urandom_range(0, 3) != 0);
      loads = $urandom_range(1, 6);
      repeat (loads) begin
         if (!range_empty() && $urandom_range(0, 9) < 8) load_random(pick_in_range());
         else noise_item();
      end
      if ($urandom_range(0, 1) != 0) read_loaded();
      ticks = 0;
      while (sb.fading && ticks < 60) begin
         send_request(FUNC_TICK, $urandom_range(0, 1023), $urandom, $urandom);
         ticks++;
         case ($urandom_range(0, 9))
            0, 1, 2: read_loaded();
            3: noise_item();
            4: if (!range_empty() && ticks < 30) load_random(pick_in_range());
            default: ;
         endcase
      end
      if ($urandom_range(0, 3) == 0)
         send_request(FUNC_TICK, $urandom_range(0, 1023), $urandom, $urandom);
   endtask

   initial begin
      int phase, first, count, sel;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset range: idle tick, no-op, out-of-range index, extreme loads
      send_request(FUNC_TICK, 0, 0, 0);
      send_request(FUNC_NOP, 1023, 255, 255);
      send_request(FUNC_READ, 1023, 0, 0);
      send_request(FUNC_LOAD, 767, 255, 0);
      send_request(FUNC_LOAD, 0, 0, 255);
      send_request(FUNC_LOAD, 1, 7, 7);
      send_request(FUNC_LOAD, 2, 10, 11);
      send_request(FUNC_LOAD, 1000, 255, 255);
      send_request(FUNC_READ, 768, 0, 0);
      send_request(FUNC_TICK, 0, 0, 0);
      send_request(FUNC_READ, 0, 0, 0);
      send_request(FUNC_READ, 2, 0, 0);
      send_request(FUNC_READ, 767, 0, 0);
      send_request(FUNC_READ, 1, 0, 0);
      // range running past the palette end
      settle();
      set_range(255, 256);
      send_request(FUNC_TICK, 0, 0, 0);
      send_request(FUNC_READ, 767, 0, 0);
      send_request(FUNC_READ, 0, 0, 0);
      // empty range ends the fade at once
      settle();
      set_range(0, 0);
      send_request(FUNC_TICK, 0, 0, 0);
      send_request(FUNC_TICK, 0, 0, 0);
      // load outside the range
      settle();
      set_range(1, 1);
      send_request(FUNC_LOAD, 9, 40, 20);
      send_request(FUNC_TICK, 0, 0, 0);
      send_request(FUNC_READ, 9, 0, 0);

      phase = 0;
      while (n_items < ITEM_TARGET) begin
         if (phase % 4 == 0) begin
            sel = $urandom_range(0, 4);
            first = first_picks[sel];
            count = count_picks[$urandom_range(0, 4)];
         end else begin
            first = $urandom_range(0, 255);
            count = $urandom_range(1, 6);
         end
         run_fade_phase(first, count);
         phase++;
      end

      stop_requests();
      while (sb.pending() != 0) @(posedge clock);
      repeat (800) @(posedge clock);

      $display("%0d items over %0d range settings: %0d loads, %0d reads, %0d fade steps",
               n_items, n_settings, sb.n_loads, sb.n_reads, sb.n_steps);
      $display("%0d fades finished, %0d results checked, %0d mismatches",
               sb.n_finishes, sb.n_checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
